// File: hdl/sphr_pkg.sv
package sphr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd3;

    // radius after reset is 1.0
    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // stage counts of the bit-per-stage units
    localparam int FRONT_STAGES = 7;
    localparam int DSQRT_STAGES = 66;
    localparam int TDIV_STAGES  = 31;
    localparam int LSQRT_STAGES = 33;
    localparam int NDIV_STAGES  = 17;

    // split multiplier operand and half widths
    localparam int WM_W = 66;
    localparam int WM_H = 33;

    // one ray as it arrives, origin_x in the lowest bits
    typedef struct packed {
        logic [30:0] max_distance;
        logic [31:0] dir_z;
        logic [31:0] dir_y;
        logic [31:0] dir_x;
        logic [31:0] origin_z;
        logic [31:0] origin_y;
        logic [31:0] origin_x;
    } ray_in_t;

    // sphere settings
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] radius;
    } sphere_t;

    // ray fields carried along the pipeline
    typedef struct packed {
        logic [30:0]      maxd;
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } pass_t;

    // quadratic terms handed to the root stages
    typedef struct packed {
        logic        miss;
        logic        hneg;
        logic [64:0] hmag;
        logic [63:0] amag;
        pass_t       p;
    } ray_t;

    // ray parameter of the hit
    typedef struct packed {
        logic        miss;
        logic [30:0] t;
        pass_t       p;
    } tval_t;

    // hit point and normal vector terms
    typedef struct packed {
        logic             miss;
        logic [30:0]      t;
        logic [2:0][31:0] p;
        logic [2:0]       nneg;
        logic [2:0][32:0] nmag;
    } surf_t;

    // result item, hit_distance in the lowest bits
    typedef struct packed {
        logic [17:0] normal_z;
        logic [17:0] normal_y;
        logic [17:0] normal_x;
        logic [31:0] point_z;
        logic [31:0] point_y;
        logic [31:0] point_x;
        logic [30:0] hit_distance;
    } result_t;

endpackage

// File: hdl/sphr_wmul.sv
module sphr_wmul
    import sphr_pkg::*;
(
    input  logic                aclk,
    input  logic                adv,
    input  logic [WM_W-1:0]     a,
    input  logic [WM_W-1:0]     b,
    output logic [2*WM_W-1:0]   p
);

    logic [2*WM_H-1:0] pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
    logic [2*WM_W-1:0] p_reg;

    // partial products of the half words
    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_hh_reg <= a[WM_W-1:WM_H] * b[WM_W-1:WM_H];
            pp_hl_reg <= a[WM_W-1:WM_H] * b[WM_H-1:0];
            pp_lh_reg <= a[WM_H-1:0] * b[WM_W-1:WM_H];
            pp_ll_reg <= a[WM_H-1:0] * b[WM_H-1:0];
        end
    end

    // weighted sum of the partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= ((2*WM_W)'(pp_hh_reg) << (2*WM_H))
                   + (((2*WM_W)'(pp_hl_reg) + (2*WM_W)'(pp_lh_reg)) << WM_H)
                   + (2*WM_W)'(pp_ll_reg);
        end
    end

    assign p = p_reg;

endmodule

// File: hdl/sphr_front.sv
module sphr_front
    import sphr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_vld,
    input  ray_in_t       in_ray,
    input  sphere_t       sph,
    output logic          out_vld,
    output logic [131:0]  disc,
    output ray_t          out_ray
);

    logic [FRONT_STAGES-1:0] vld_reg;
    pass_t                   pass_reg [3];
    logic signed [32:0]      oc_reg [3];
    logic [62:0]             dd_reg [3];
    logic signed [64:0]      od_reg [3];
    logic [64:0]             oo_reg [3];
    logic [61:0]             r2_reg;
    logic [63:0]             a_reg;
    logic signed [66:0]      h_reg;
    logic signed [67:0]      c_reg;
    ray_t                    ray4_reg, ray5_reg, ray6_reg, ray7_reg;
    logic                    cneg4_reg, cneg5_reg, cneg6_reg;
    logic [65:0]             cmag4_reg;
    logic [131:0]            disc_reg;
    logic [131:0]            h2, ac;
    logic [2:0][31:0]        o_in, d_in, c_in;
    pass_t                   pass_in;

    assign o_in = {in_ray.origin_z, in_ray.origin_y, in_ray.origin_x};
    assign d_in = {in_ray.dir_z, in_ray.dir_y, in_ray.dir_x};
    assign c_in = {sph.cz, sph.cy, sph.cx};
    assign pass_in = '{maxd: in_ray.max_distance, o: o_in, d: d_in};

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_vld};
        end
    end

    // origin minus center, then the products
    always_ff @(posedge aclk) begin
        if (adv) begin
            pass_reg[0] <= pass_in;
            pass_reg[1] <= pass_reg[0];
            pass_reg[2] <= pass_reg[1];
            for (int i = 0; i < 3; i++) begin
                oc_reg[i] <= $signed({o_in[i][31], o_in[i]}) - $signed({c_in[i][31], c_in[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [63:0] ddp;
        logic signed [64:0] odp;
        logic signed [65:0] oop;
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                ddp = $signed(pass_reg[0].d[i]) * $signed(pass_reg[0].d[i]);
                odp = oc_reg[i] * $signed(pass_reg[0].d[i]);
                oop = oc_reg[i] * oc_reg[i];
                dd_reg[i] <= ddp[62:0];
                od_reg[i] <= odp;
                oo_reg[i] <= oop[64:0];
            end
            r2_reg <= 62'(sph.radius) * 62'(sph.radius);
        end
    end

    // A, H and C
    always_ff @(posedge aclk) begin
        logic [66:0] oos;
        if (adv) begin
            a_reg <= 64'(dd_reg[0]) + 64'(dd_reg[1]) + 64'(dd_reg[2]);
            h_reg <= 67'(od_reg[0]) + 67'(od_reg[1]) + 67'(od_reg[2]);
            oos = 67'(oo_reg[0]) + 67'(oo_reg[1]) + 67'(oo_reg[2]);
            c_reg <= $signed({1'b0, oos}) - $signed(68'(r2_reg));
        end
    end

    // sign and magnitude split, zero direction is a miss
    always_ff @(posedge aclk) begin
        logic signed [66:0] hn;
        logic signed [67:0] cn;
        if (adv) begin
            hn = -h_reg;
            cn = -c_reg;
            ray4_reg.miss <= (a_reg == '0);
            ray4_reg.hneg <= h_reg[66];
            ray4_reg.hmag <= h_reg[66] ? 65'(hn) : 65'(h_reg);
            ray4_reg.amag <= a_reg;
            ray4_reg.p    <= pass_reg[2];
            cneg4_reg     <= c_reg[67];
            cmag4_reg     <= c_reg[67] ? 66'(cn) : 66'(c_reg);
        end
    end

    // H squared and A times C
    sphr_wmul u_mul_h2 (
        .aclk (aclk),
        .adv  (adv),
        .a    (66'(ray4_reg.hmag)),
        .b    (66'(ray4_reg.hmag)),
        .p    (h2)
    );

    sphr_wmul u_mul_ac (
        .aclk (aclk),
        .adv  (adv),
        .a    (66'(ray4_reg.amag)),
        .b    (cmag4_reg),
        .p    (ac)
    );

    // discriminant, negative means a miss
    always_ff @(posedge aclk) begin
        ray_t r7;
        if (adv) begin
            r7 = ray6_reg;
            ray5_reg  <= ray4_reg;
            cneg5_reg <= cneg4_reg;
            ray6_reg  <= ray5_reg;
            cneg6_reg <= cneg5_reg;
            if (cneg6_reg) begin
                disc_reg <= h2 + ac;
            end else begin
                disc_reg <= h2 - ac;
                if (h2 < ac) begin
                    r7.miss = 1'b1;
                end
            end
            ray7_reg <= r7;
        end
    end

    assign out_vld = vld_reg[FRONT_STAGES-1];
    assign disc    = disc_reg;
    assign out_ray = ray7_reg;

endmodule

// File: hdl/sphr_dsqrt.sv
module sphr_dsqrt
    import sphr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_vld,
    input  logic [131:0]  disc,
    input  ray_t          in_ray,
    output logic          out_vld,
    output logic [65:0]   root,
    output ray_t          out_ray
);

    localparam int NS = DSQRT_STAGES;

    logic [NS-1:0] vld_reg;
    logic [67:0]   rem_reg  [NS];
    logic [67:0]   rem_next [NS];
    logic [65:0]   root_reg  [NS];
    logic [65:0]   root_next [NS];
    logic [131:0]  rad_reg  [NS];
    logic [131:0]  rad_next [NS];
    ray_t          ray_reg  [NS];
    ray_t          ray_next [NS];

    // one root bit per stage, two radicand bits shifted in
    always_comb begin
        logic [67:0]  rs, rsh, tr;
        logic [65:0]  ro;
        logic [131:0] ra;
        ray_t         ry;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rs = '0;
                ro = '0;
                ra = disc;
                ry = in_ray;
            end else begin
                rs = rem_reg[k-1];
                ro = root_reg[k-1];
                ra = rad_reg[k-1];
                ry = ray_reg[k-1];
            end
            rsh = {rs[65:0], ra[131-2*k -: 2]};
            tr  = {ro, 2'b01};
            if (rsh >= tr) begin
                rem_next[k]  = rsh - tr;
                root_next[k] = {ro[64:0], 1'b1};
            end else begin
                rem_next[k]  = rsh;
                root_next[k] = {ro[64:0], 1'b0};
            end
            rad_next[k] = ra;
            ray_next[k] = ry;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NS; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                ray_reg[k]  <= ray_next[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign root    = root_reg[NS-1];
    assign out_ray = ray_reg[NS-1];

endmodule

// File: hdl/sphr_tdiv.sv
module sphr_tdiv
    import sphr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_vld,
    input  logic [65:0]  root,
    input  ray_t         in_ray,
    output logic         out_vld,
    output tval_t        out_t
);

    localparam int NS = TDIV_STAGES;
    localparam int NV = TDIV_STAGES + 3;

    logic [NV-1:0] vld_reg;
    logic [66:0]   n0_reg;
    ray_t          ray0_reg, ray1_reg;
    logic [82:0]   rem1_reg;
    logic [82:0]   rem_reg  [NS];
    logic [82:0]   rem_next [NS];
    logic [30:0]   q_reg  [NS];
    logic [30:0]   q_next [NS];
    ray_t          ray_reg  [NS];
    ray_t          ray_next [NS];
    tval_t         tv_reg;

    // pick the near root, or the far one if the near one is negative
    always_ff @(posedge aclk) begin
        logic [66:0] s67, h67;
        ray_t        r0;
        if (adv) begin
            s67 = 67'(root);
            h67 = 67'(in_ray.hmag);
            r0  = in_ray;
            if (in_ray.hneg) begin
                n0_reg <= (h67 >= s67) ? h67 - s67 : h67 + s67;
            end else begin
                n0_reg <= s67 - h67;
                if (s67 < h67) begin
                    r0.miss = 1'b1;
                end
            end
            ray0_reg <= r0;
        end
    end

    // a quotient of 2^31 or more is beyond any range
    always_ff @(posedge aclk) begin
        ray_t r1;
        if (adv) begin
            r1 = ray0_reg;
            rem1_reg <= {n0_reg, 16'b0};
            if (95'({n0_reg, 16'b0}) >= {ray0_reg.amag, 31'b0}) begin
                r1.miss = 1'b1;
            end
            ray1_reg <= r1;
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [82:0] rs;
        logic [30:0] qs;
        logic [94:0] dv;
        ray_t        ry;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rs = rem1_reg;
                qs = '0;
                ry = ray1_reg;
            end else begin
                rs = rem_reg[k-1];
                qs = q_reg[k-1];
                ry = ray_reg[k-1];
            end
            dv = 95'(ry.amag) << (NS - 1 - k);
            if (95'(rs) >= dv) begin
                rem_next[k] = 83'(95'(rs) - dv);
                q_next[k]   = {qs[29:0], 1'b1};
            end else begin
                rem_next[k] = rs;
                q_next[k]   = {qs[29:0], 1'b0};
            end
            ray_next[k] = ry;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NS; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                ray_reg[k] <= ray_next[k];
            end
        end
    end

    // range check against max_distance
    always_ff @(posedge aclk) begin
        if (adv) begin
            tv_reg.miss <= ray_reg[NS-1].miss | (q_reg[NS-1] > ray_reg[NS-1].p.maxd);
            tv_reg.t    <= q_reg[NS-1];
            tv_reg.p    <= ray_reg[NS-1].p;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NV-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[NV-1];
    assign out_t   = tv_reg;

endmodule

// File: hdl/sphr_shade.sv
module sphr_shade
    import sphr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  logic     in_vld,
    input  tval_t    in_t,
    input  sphere_t  sph,
    output logic     out_vld,
    output logic     out_hit,
    output result_t  out_res
);

    localparam int LS = LSQRT_STAGES;
    localparam int DS = NDIV_STAGES;
    localparam int NV = 5 + LSQRT_STAGES + NDIV_STAGES;
    localparam logic signed [48:0] SAT_HI = 49'sh0_7FFF_FFFF;
    localparam logic signed [48:0] SAT_LO = -49'sh0_8000_0000;

    logic [NV-1:0]      vld_reg;
    tval_t              tv1_reg;
    logic [62:0]        m_reg [3];
    surf_t              surf2_reg, surf3_reg, surf4_reg, surf5_reg;
    logic signed [32:0] n_reg [3];
    logic [64:0]        sq_reg [3];
    logic [65:0]        l2_reg;
    logic [2:0][31:0]   c_in;

    logic [34:0]        lrem_reg  [LS];
    logic [34:0]        lrem_next [LS];
    logic [32:0]        lroot_reg  [LS];
    logic [32:0]        lroot_next [LS];
    logic [65:0]        lrad_reg  [LS];
    logic [65:0]        lrad_next [LS];
    surf_t              lsurf_reg  [LS];
    surf_t              lsurf_next [LS];

    logic [2:0][48:0]   nrem_reg  [DS];
    logic [2:0][48:0]   nrem_next [DS];
    logic [2:0][16:0]   nq_reg  [DS];
    logic [2:0][16:0]   nq_next [DS];
    logic [32:0]        nl_reg  [DS];
    logic [32:0]        nl_next [DS];
    surf_t              nsurf_reg  [DS];
    surf_t              nsurf_next [DS];

    assign c_in = {sph.cz, sph.cy, sph.cx};

    // direction magnitude times t
    always_ff @(posedge aclk) begin
        logic [31:0] dabs;
        if (adv) begin
            tv1_reg <= in_t;
            for (int i = 0; i < 3; i++) begin
                dabs = in_t.p.d[i][31] ? 32'(-in_t.p.d[i]) : in_t.p.d[i];
                m_reg[i] <= 63'(dabs) * 63'(in_t.t);
            end
        end
    end

    // hit point: floor of the step, saturated to 32 bits
    always_ff @(posedge aclk) begin
        logic [48:0]        fl, ce;
        logic signed [48:0] sv;
        if (adv) begin
            surf2_reg.miss <= tv1_reg.miss;
            surf2_reg.t    <= tv1_reg.t;
            surf2_reg.nneg <= '0;
            surf2_reg.nmag <= '0;
            for (int i = 0; i < 3; i++) begin
                fl = 49'(m_reg[i][62:16]);
                ce = 49'((64'(m_reg[i]) + 64'd65535) >> 16);
                sv = $signed({{17{tv1_reg.p.o[i][31]}}, tv1_reg.p.o[i]})
                   + (tv1_reg.p.d[i][31] ? -$signed(ce) : $signed(fl));
                if (sv > SAT_HI) begin
                    surf2_reg.p[i] <= 32'h7FFF_FFFF;
                end else if (sv < SAT_LO) begin
                    surf2_reg.p[i] <= 32'h8000_0000;
                end else begin
                    surf2_reg.p[i] <= sv[31:0];
                end
            end
        end
    end

    // vector from center to hit point
    always_ff @(posedge aclk) begin
        if (adv) begin
            surf3_reg <= surf2_reg;
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= $signed({surf2_reg.p[i][31], surf2_reg.p[i]})
                          - $signed({c_in[i][31], c_in[i]});
            end
        end
    end

    // magnitudes and squares
    always_ff @(posedge aclk) begin
        logic signed [65:0] sqp;
        logic signed [32:0] nn;
        surf_t              s4;
        if (adv) begin
            s4 = surf3_reg;
            for (int i = 0; i < 3; i++) begin
                sqp = n_reg[i] * n_reg[i];
                nn  = -n_reg[i];
                sq_reg[i]  <= sqp[64:0];
                s4.nneg[i] = n_reg[i][32];
                s4.nmag[i] = n_reg[i][32] ? nn : n_reg[i];
            end
            surf4_reg <= s4;
        end
    end

    // squared length
    always_ff @(posedge aclk) begin
        if (adv) begin
            surf5_reg <= surf4_reg;
            l2_reg    <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        end
    end

    // length by square root, one bit per stage
    always_comb begin
        logic [34:0] rs, rsh, tr;
        logic [32:0] ro;
        logic [65:0] ra;
        surf_t       sf;
        for (int k = 0; k < LS; k++) begin
            if (k == 0) begin
                rs = '0;
                ro = '0;
                ra = l2_reg;
                sf = surf5_reg;
            end else begin
                rs = lrem_reg[k-1];
                ro = lroot_reg[k-1];
                ra = lrad_reg[k-1];
                sf = lsurf_reg[k-1];
            end
            rsh = {rs[32:0], ra[65-2*k -: 2]};
            tr  = {ro, 2'b01};
            if (rsh >= tr) begin
                lrem_next[k]  = rsh - tr;
                lroot_next[k] = {ro[31:0], 1'b1};
            end else begin
                lrem_next[k]  = rsh;
                lroot_next[k] = {ro[31:0], 1'b0};
            end
            lrad_next[k]  = ra;
            lsurf_next[k] = sf;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < LS; k++) begin
                lrem_reg[k]  <= lrem_next[k];
                lroot_reg[k] <= lroot_next[k];
                lrad_reg[k]  <= lrad_next[k];
                lsurf_reg[k] <= lsurf_next[k];
            end
        end
    end

    // normal components: magnitude * 65536 / length, one bit per stage
    always_comb begin
        logic [2:0][48:0] rs;
        logic [2:0][16:0] qs;
        logic [32:0]      lv;
        logic [48:0]      dv;
        surf_t            sf;
        for (int k = 0; k < DS; k++) begin
            if (k == 0) begin
                sf = lsurf_reg[LS-1];
                lv = lroot_reg[LS-1];
                qs = '0;
                for (int i = 0; i < 3; i++) begin
                    rs[i] = {sf.nmag[i], 16'b0};
                end
            end else begin
                sf = nsurf_reg[k-1];
                lv = nl_reg[k-1];
                qs = nq_reg[k-1];
                rs = nrem_reg[k-1];
            end
            dv = 49'(lv) << (DS - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if (rs[i] >= dv) begin
                    nrem_next[k][i] = rs[i] - dv;
                    nq_next[k][i]   = {qs[i][15:0], 1'b1};
                end else begin
                    nrem_next[k][i] = rs[i];
                    nq_next[k][i]   = {qs[i][15:0], 1'b0};
                end
            end
            nl_next[k]    = lv;
            nsurf_next[k] = sf;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DS; k++) begin
                nrem_reg[k]  <= nrem_next[k];
                nq_reg[k]    <= nq_next[k];
                nl_reg[k]    <= nl_next[k];
                nsurf_reg[k] <= nsurf_next[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NV-2:0], in_vld};
        end
    end

    // result item, all zero on a miss
    always_comb begin
        surf_t            sf;
        logic [2:0][17:0] nv;
        sf = nsurf_reg[DS-1];
        for (int i = 0; i < 3; i++) begin
            if (nl_reg[DS-1] == '0) begin
                nv[i] = '0;
            end else if (sf.nneg[i]) begin
                nv[i] = -18'(nq_reg[DS-1][i]);
            end else begin
                nv[i] = 18'(nq_reg[DS-1][i]);
            end
        end
        if (sf.miss) begin
            out_hit = 1'b0;
            out_res = '0;
        end else begin
            out_hit              = 1'b1;
            out_res.hit_distance = sf.t;
            out_res.point_x      = sf.p[0];
            out_res.point_y      = sf.p[1];
            out_res.point_z      = sf.p[2];
            out_res.normal_x     = nv[0];
            out_res.normal_y     = nv[1];
            out_res.normal_z     = nv[2];
        end
    end

    assign out_vld = vld_reg[NV-1];

endmodule

// File: hdl/ray_sphere_intersect.sv
// Ray against sphere test in signed Q16.16. Each ray item on s_tdata gives the
// hit flag (m_tuser), the distance t, the hit point and the unit surface normal
// on m_tdata; a miss gives all zeros. The sphere center and radius are written
// through the cfg port; the user must write them only while no ray is in flight,
// which the block itself does not enforce. The pipeline takes one ray every clock;
// its main parts are the 66-stage square root of the discriminant, the 31-stage
// divider for t, and the 33-stage length root plus 17-stage divider for the normal.
// A stall on m_tready freezes the whole pipeline.
module ray_sphere_intersect
    import sphr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, pad
    input  logic [223:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit_distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, pad
    output logic [183:0]         m_tdata,
    // hit
    output logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic        adv;
    logic [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] radius_reg;
    sphere_t     sph;
    ray_in_t     in_ray;

    logic        f_vld, q_vld, t_vld, s_vld, s_hit;
    logic [131:0] disc;
    ray_t        f_ray, q_ray;
    logic [65:0] root;
    tval_t       tv;
    result_t     s_res;

    logic        m_tvalid_reg;
    logic        m_hit_reg;
    result_t     m_res_reg;

    // whole pipeline moves unless a result is held
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // sphere registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CENTER_X: cx_reg     <= cfg_data;
                REG_CENTER_Y: cy_reg     <= cfg_data;
                REG_CENTER_Z: cz_reg     <= cfg_data;
                REG_RADIUS:   radius_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign sph    = '{cx: cx_reg, cy: cy_reg, cz: cz_reg, radius: radius_reg};
    assign in_ray = ray_in_t'(s_tdata[222:0]);

    sphr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .in_ray  (in_ray),
        .sph     (sph),
        .out_vld (f_vld),
        .disc    (disc),
        .out_ray (f_ray)
    );

    sphr_dsqrt u_dsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (f_vld),
        .disc    (disc),
        .in_ray  (f_ray),
        .out_vld (q_vld),
        .root    (root),
        .out_ray (q_ray)
    );

    sphr_tdiv u_tdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (q_vld),
        .root    (root),
        .in_ray  (q_ray),
        .out_vld (t_vld),
        .out_t   (tv)
    );

    sphr_shade u_shade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (t_vld),
        .in_t    (tv),
        .sph     (sph),
        .out_vld (s_vld),
        .out_hit (s_hit),
        .out_res (s_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= s_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_res_reg <= s_res;
            m_hit_reg <= s_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg};
    assign m_tuser  = m_hit_reg;

endmodule
